### src/pla_pkg.sv
// package for the path lookahead reference block
// types, opcodes, status codes and fixed-point helpers; no dependencies
package pla_pkg;

  localparam int unsigned PathDepthDef  = 1024;
  localparam int unsigned MaxHorizonDef = 32;
  localparam int unsigned HorizonRst    = 10;
  localparam int unsigned FifoDepth     = 4;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [9:0]         point_index;
    logic signed [31:0] ref_world_x;
    logic signed [31:0] ref_world_y;
    logic signed [31:0] ref_robot_x;
    logic signed [31:0] ref_robot_y;
    logic               last;
  } out_item_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_APPEND,
    BK_SIMPLE,
    BK_SCAN_RD,
    BK_SCAN,
    BK_SCAN_END,
    BK_TRIG,
    BK_EMIT_RD,
    BK_EMIT_MUL,
    BK_EMIT_SUM,
    BK_EMIT_OUT
  } bk_state_e;

  typedef enum logic [2:0] {
    TR_Z2,
    TR_IN1,
    TR_IN3,
    TR_S,
    TR_DONE
  } trig_state_e;

  // v / 65536 rounded half up, saturated to int32
  function automatic logic [31:0] scale_sat(input logic signed [65:0] v);
    logic signed [65:0] r;
    begin
      r = (v + 66'sd32768) >>> 16;
      if (r > 66'sd2147483647) scale_sat = 32'h7fffffff;
      else if (r < -66'sd2147483648) scale_sat = 32'h80000000;
      else scale_sat = r[31:0];
    end
  endfunction

endpackage

### src/pla_front.sv
// front end: accepts input transactions and classifies them into the command queue
// depends on pla_pkg
module pla_front
  import pla_pkg::*;
#(
  parameter int unsigned FDepth = FifoDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  output logic     full_o,
  input  in_item_t in_item_i,
  output logic     cmd_valid_o,
  input  logic     cmd_pop_i,
  output in_item_t cmd_o
);
  localparam int unsigned Aw = $clog2(FDepth);

  in_item_t mem_q [FDepth];
  logic [Aw-1:0] wr_q, rd_q;
  logic [Aw:0]   cnt_q;
  logic wr, rd;

  // unused opcode is dropped here, it causes nothing
  assign full_o      = (cnt_q == (Aw+1)'(FDepth));
  assign wr          = push_i && !full_o && (in_item_i.opcode != OP_NONE);
  assign cmd_valid_o = (cnt_q != '0);
  assign rd          = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wr_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wr_q <= (wr_q == Aw'(FDepth-1)) ? '0 : wr_q + 1'b1;
      if (rd) rd_q <= (rd_q == Aw'(FDepth-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(wr) - (Aw+1)'(rd);
    end
  end
endmodule

### src/pla_trig.sv
// sine of a heading angle, one polynomial product per cycle
// depends on pla_pkg
module pla_trig
  import pla_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [15:0]        angle_i,
  output logic               done_o,
  output logic signed [17:0] sin_o
);
  trig_state_e st_q, st_d;
  logic [16:0] z_q;
  logic [33:0] z2_q, acc_q;
  logic [1:0]  quad_q;
  logic [33:0] prod;
  logic [13:0] t;
  logic [14:0] tq;
  logic [16:0] s;

  assign t  = angle_i[13:0];
  assign tq = angle_i[14] ? 15'd16384 - {1'b0, t} : {1'b0, t};

  always_comb begin
    st_d = st_q;
    prod = '0;
    case (st_q)
      TR_Z2:  prod = 34'(z_q) * 34'(z_q);
      TR_IN1: prod = 34'(4640) * z2_q;
      TR_IN3: prod = z2_q * (34'(42047) - acc_q);
      TR_S:   prod = 34'(z_q) * (34'(102944) - acc_q);
      default: prod = '0;
    endcase
    case (st_q)
      TR_Z2:  st_d = TR_IN1;
      TR_IN1: st_d = TR_IN3;
      TR_IN3: st_d = TR_S;
      TR_S:   st_d = TR_DONE;
      default: st_d = TR_DONE;
    endcase
  end

  assign s = (acc_q > 34'd65536) ? 17'd65536 : acc_q[16:0];
  assign sin_o  = quad_q[1] ? -$signed({1'b0, s}) : $signed({1'b0, s});
  assign done_o = (st_q == TR_DONE);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      z_q    <= {tq, 2'b00};
      quad_q <= angle_i[15:14];
    end else begin
      case (st_q)
        TR_Z2: z2_q <= prod >> 16;
        TR_IN1, TR_IN3, TR_S: acc_q <= prod >> 16;
        default: acc_q <= acc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= TR_DONE;
    else if (start_i) st_q <= TR_Z2;
    else st_q <= st_d;
  end
endmodule

### src/pla_back.sv
// back end: path store, nearest-point scan and lookahead emission
// depends on pla_pkg and pla_trig
module pla_back
  import pla_pkg::*;
#(
  parameter int unsigned PathDepth  = PathDepthDef,
  parameter int unsigned MaxHorizon = MaxHorizonDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_pop_o,
  input  in_item_t  cmd_i,
  input  logic [5:0] horizon_i,
  output logic      res_valid_o,
  input  logic      res_pop_i,
  output out_item_t res_o
);
  localparam int unsigned Aw = $clog2(PathDepth);
  localparam int unsigned Cw = $clog2(PathDepth+1);
  localparam int unsigned Hw = $clog2(MaxHorizon+1);

  logic [31:0] xs_q [PathDepth];
  logic [31:0] ys_q [PathDepth];
  logic [31:0] rdx_q, rdy_q;
  logic [Aw-1:0] raddr;

  bk_state_e st_q, st_d;
  logic [Cw-1:0] cnt_q;
  in_item_t cur_q;
  logic [Aw-1:0] idx_q, best_q;
  logic [Cw:0] scan_q;
  logic [63:0] sqx_q, sqy_q;
  logic [64:0] best_d2_q;
  logic [Hw-1:0] left_q;
  logic signed [17:0] sin_q, cos_q;
  logic trig_phase_q;
  logic signed [51:0] pxc_q, pys_q, pyc_q, pxs_q;
  logic signed [65:0] fwd_q, lat_q;
  out_item_t res_q, res_d;
  logic res_v_q;

  logic trig_start, trig_done;
  logic signed [17:0] trig_sin;
  logic [31:0] ax, ay;
  logic [64:0] d2;
  logic signed [32:0] dxw, dyw;
  logic [Hw-1:0] hcnt;
  logic [Aw-1:0] nxt_idx;

  assign res_valid_o = res_v_q;
  assign res_o = res_q;

  always_comb begin
    if (horizon_i == 6'd0) hcnt = Hw'(1);
    else if (7'(horizon_i) > 7'(MaxHorizon)) hcnt = Hw'(MaxHorizon);
    else hcnt = Hw'(horizon_i);
  end

  assign raddr = (st_q == BK_SCAN_RD) ? '0 : (st_q == BK_SCAN) ? scan_q[Aw-1:0] : idx_q;

  always_ff @(posedge clk_i) begin
    if (st_q == BK_APPEND && cnt_q < Cw'(PathDepth)) begin
      xs_q[cnt_q[Aw-1:0]] <= cur_q.pos_x;
      ys_q[cnt_q[Aw-1:0]] <= cur_q.pos_y;
    end
    rdx_q <= xs_q[raddr];
    rdy_q <= ys_q[raddr];
  end

  assign dxw = 33'($signed(rdx_q)) - 33'(cur_q.pos_x);
  assign dyw = 33'($signed(rdy_q)) - 33'(cur_q.pos_y);
  assign ax = dxw[32] ? 32'(-dxw) : dxw[31:0];
  assign ay = dyw[32] ? 32'(-dyw) : dyw[31:0];
  // squares are registered, the compare runs one point behind the read
  assign d2 = 65'(sqx_q) + 65'(sqy_q);

  assign trig_start = (st_q == BK_SCAN_END) || (st_q == BK_TRIG && trig_done && !trig_phase_q);

  pla_trig u_trig (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(trig_start),
    .angle_i(st_q == BK_SCAN_END ? cur_q.heading : cur_q.heading + 16'd16384),
    .done_o (trig_done),
    .sin_o  (trig_sin)
  );

  assign nxt_idx = (32'(idx_q) + 32'd1 >= 32'(cnt_q)) ? '0 : idx_q + 1'b1;

  always_comb begin
    st_d = st_q;
    cmd_pop_o = 1'b0;
    case (st_q)
      BK_IDLE: if (cmd_valid_i) begin
        cmd_pop_o = 1'b1;
        case (cmd_i.opcode)
          OP_APPEND: st_d = BK_APPEND;
          OP_QUERY:  st_d = (cnt_q == '0) ? BK_SIMPLE : BK_SCAN_RD;
          default:   st_d = BK_SIMPLE;
        endcase
      end
      BK_APPEND, BK_SIMPLE: if (!res_v_q) st_d = BK_IDLE;
      BK_SCAN_RD: st_d = BK_SCAN;
      BK_SCAN: if (scan_q == (Cw+1)'(cnt_q) + (Cw+1)'(1)) st_d = BK_SCAN_END;
      BK_SCAN_END: st_d = BK_TRIG;
      BK_TRIG: if (trig_done && trig_phase_q) st_d = BK_EMIT_RD;
      BK_EMIT_RD: st_d = BK_EMIT_MUL;
      BK_EMIT_MUL: st_d = BK_EMIT_SUM;
      BK_EMIT_SUM: st_d = BK_EMIT_OUT;
      BK_EMIT_OUT: if (!res_v_q) st_d = (left_q == Hw'(1)) ? BK_IDLE : BK_EMIT_RD;
      default: st_d = BK_IDLE;
    endcase
  end

  always_comb begin
    res_d = '0;
    res_d.last = 1'b1;
    case (st_q)
      BK_APPEND: if (cnt_q < Cw'(PathDepth)) begin
        res_d.point_index = 10'(cnt_q);
        res_d.ref_world_x = cur_q.pos_x;
        res_d.ref_world_y = cur_q.pos_y;
      end else res_d.status = ST_FULL;
      BK_SIMPLE: if (cur_q.opcode == OP_QUERY) res_d.status = ST_EMPTY;
      BK_EMIT_OUT: begin
        res_d.point_index = 10'(idx_q);
        res_d.ref_world_x = rdx_q;
        res_d.ref_world_y = rdy_q;
        res_d.ref_robot_x = scale_sat(fwd_q);
        res_d.ref_robot_y = scale_sat(lat_q);
        res_d.last = (left_q == Hw'(1));
      end
      default: res_d.last = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == BK_IDLE && cmd_valid_i) cur_q <= cmd_i;
    if (st_q == BK_SCAN_RD) scan_q <= (Cw+1)'(1);
    if (st_q == BK_SCAN) begin
      // rdx_q holds entry scan_q-1, the squares hold entry scan_q-2
      sqx_q <= 64'(ax) * 64'(ax);
      sqy_q <= 64'(ay) * 64'(ay);
      if (scan_q == (Cw+1)'(2) || (scan_q > (Cw+1)'(2) && d2 < best_d2_q)) begin
        best_d2_q <= d2;
        best_q <= Aw'(scan_q - (Cw+1)'(2));
      end
      scan_q <= scan_q + 1'b1;
    end
    if (st_q == BK_SCAN_END) begin
      idx_q <= best_q;
      left_q <= hcnt;
    end
    if (st_q == BK_TRIG && trig_done && !trig_phase_q) sin_q <= trig_sin;
    if (st_q == BK_TRIG && trig_done && trig_phase_q) cos_q <= trig_sin;
    if (st_q == BK_EMIT_MUL) begin
      pxc_q <= 52'(dxw) * 52'(cos_q);
      pys_q <= 52'(dyw) * 52'(sin_q);
      pyc_q <= 52'(dyw) * 52'(cos_q);
      pxs_q <= 52'(dxw) * 52'(sin_q);
    end
    if (st_q == BK_EMIT_SUM) begin
      fwd_q <= 66'(pxc_q) + 66'(pys_q);
      lat_q <= 66'(pyc_q) - 66'(pxs_q);
    end
    if (st_q == BK_EMIT_OUT && !res_v_q) begin
      idx_q <= nxt_idx;
      left_q <= left_q - 1'b1;
    end
    if (!res_v_q) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE;
      cnt_q <= '0;
      res_v_q <= 1'b0;
      trig_phase_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == BK_SCAN_END) trig_phase_q <= 1'b0;
      else if (st_q == BK_TRIG && trig_done) trig_phase_q <= 1'b1;
      if (st_q == BK_APPEND && !res_v_q && cnt_q < Cw'(PathDepth)) cnt_q <= cnt_q + 1'b1;
      if (st_q == BK_SIMPLE && !res_v_q && cur_q.opcode == OP_CLEAR) cnt_q <= '0;
      if (!res_v_q && (st_q == BK_APPEND || st_q == BK_SIMPLE || st_q == BK_EMIT_OUT))
        res_v_q <= 1'b1;
      else if (res_pop_i) res_v_q <= 1'b0;
    end
  end
endmodule

### src/path_lookahead_reference.sv
// path lookahead reference: top level with apb register and queue ports
// depends on pla_pkg, pla_front, pla_back
//
// input channel: push/full carries in_item_i (append, query, clear).
// result channel: empty/pop carries out_item_o; the oldest result is shown
// while empty is low and leaves on pop.
// apb register 0 at address 0: horizon, reset 10.
// a front queue of four commands decouples the input from the back end.
// append and clear each give one result.
// a query scans all n stored points, one per cycle, through a registered
// read and registered squares, then computes sine and cosine in the trig
// block, then emits each lookahead point through read, multiply, sum and
// output steps; no new command is taken before the last result is issued.
// reset empties the path and the queues; stored points are not cleared.
// when the receiver stalls, the back end holds its result and stops; the
// front queue keeps accepting until it is full.
module path_lookahead_reference
  import pla_pkg::*;
#(
  parameter int unsigned PathDepth  = PathDepthDef,
  parameter int unsigned MaxHorizon = MaxHorizonDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item_i,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [5:0] horizon_q;
  logic cmd_valid, cmd_pop, res_valid;
  in_item_t cmd;

  assign pready = 1'b1;
  assign prdata = {26'd0, horizon_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) horizon_q <= 6'(HorizonRst);
    else if (psel && penable && pwrite && !paddr) horizon_q <= pwdata[5:0];
  end

  pla_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .in_item_i  (in_item_i),
    .cmd_valid_o(cmd_valid),
    .cmd_pop_i  (cmd_pop),
    .cmd_o      (cmd)
  );

  pla_back #(.PathDepth(PathDepth), .MaxHorizon(MaxHorizon)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .cmd_i      (cmd),
    .horizon_i  (horizon_q),
    .res_valid_o(res_valid),
    .res_pop_i  (pop),
    .res_o      (out_item_o)
  );

  assign empty = !res_valid;
endmodule
